// ----- rtl/mstb_pkg.sv -----
// Shared types and constants for the minimum spanning tree builder.
package mstb_pkg;

  localparam int CFG_W            = 5;
  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int CMD_ADD_EDGE     = 0;
  localparam int CMD_BUILD        = 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_CLEAR
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_INIT,
    CELL_RELAX,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctl_t;

endpackage

// ----- rtl/minimum_spanning_tree_builder_top.sv -----
// Top level: command decode, Prim round sequencer, cell chain and result register.
// Add-edge transaction: back to back, no result.
// Build: per Prim round the min-key token walks the MAX_VERTICES-cell chain, then a relax step;
// up to n+1 rounds, then n-1 results at one per cycle unless out_stall_i holds, then a clear step.
// The input stalls for the whole build, until the block is back in idle.
// Reset (async, active low) clears control, edge presence and vertex count (16); no sweep.
module minimum_spanning_tree_builder_top #(
  parameter int MAX_VERTICES = mstb_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = mstb_pkg::WEIGHT_BITS_DEF,
  parameter int VW           = $clog2(MAX_VERTICES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mstb_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [VW-1:0]                 from_vertex_i,
  input  logic [VW-1:0]                 to_vertex_i,
  input  logic signed [WEIGHT_BITS-1:0] edge_weight_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [VW-1:0]                 parent_vertex_o,
  output logic [VW-1:0]                 child_vertex_o,
  output logic signed [WEIGHT_BITS-1:0] tree_edge_weight_o,
  output logic                          reachable_o,
  output logic                          last_o
);

  localparam int NW = $clog2(MAX_VERTICES + 1);

  logic [mstb_pkg::CFG_W-1:0] cfg_q;
  logic [NW-1:0]              n_eff;
  mstb_pkg::state_e           state_q, state_d;
  logic [NW-1:0]              cnt_q, cnt_d;
  logic [VW-1:0]              idx_q, idx_d;
  logic [VW-1:0]              pick_q, pick_d;
  mstb_pkg::cell_ctl_t        ctl;
  logic                       in_acc, edge_ok, out_load;

  logic                          tok_found [MAX_VERTICES+1];
  logic signed [WEIGHT_BITS-1:0] tok_low   [MAX_VERTICES+1];
  logic [VW-1:0]                 tok_pick  [MAX_VERTICES+1];
  logic                          kv        [MAX_VERTICES];
  logic                          it        [MAX_VERTICES];
  logic [VW-1:0]                 par       [MAX_VERTICES];
  logic signed [WEIGHT_BITS-1:0] pw        [MAX_VERTICES];

  logic                          out_valid_q;
  logic [VW-1:0]                 out_par_q, out_child_q;
  logic signed [WEIGHT_BITS-1:0] out_wt_q;
  logic                          out_reach_q, out_last_q;
  logic                          reach, emit_last;

  always_comb begin
    if (cfg_q < mstb_pkg::CFG_W'(2)) n_eff = NW'(2);
    else if (32'(cfg_q) > MAX_VERTICES) n_eff = NW'(MAX_VERTICES);
    else n_eff = NW'(cfg_q);
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != mstb_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign edge_ok     = (from_vertex_i != to_vertex_i) && (NW'(from_vertex_i) < n_eff) &&
                       (NW'(to_vertex_i) < n_eff);
  assign out_load    = !out_valid_q || !out_stall_i;
  assign reach       = it[idx_q] && kv[idx_q];
  assign emit_last   = NW'(idx_q) == n_eff - NW'(1);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    pick_d  = pick_q;
    ctl.op  = mstb_pkg::CELL_HOLD;
    unique case (state_q)
      mstb_pkg::S_IDLE: begin
        if (in_acc) begin
          if (cmd_i == 1'(mstb_pkg::CMD_BUILD)) begin
            ctl.op  = mstb_pkg::CELL_INIT;
            cnt_d   = '0;
            state_d = mstb_pkg::S_SCAN;
          end else if (edge_ok) begin
            ctl.op = mstb_pkg::CELL_LOAD;
          end
        end
      end
      mstb_pkg::S_SCAN: begin
        cnt_d = cnt_q + NW'(1);
        if (cnt_q == NW'(MAX_VERTICES)) begin
          cnt_d = '0;
          if (tok_found[MAX_VERTICES]) begin
            ctl.op = mstb_pkg::CELL_RELAX;
            pick_d = tok_pick[MAX_VERTICES];
          end else begin
            idx_d   = VW'(1);
            state_d = mstb_pkg::S_EMIT;
          end
        end
      end
      mstb_pkg::S_EMIT: begin
        if (out_load) begin
          idx_d = idx_q + VW'(1);
          if (emit_last) state_d = mstb_pkg::S_CLEAR;
        end
      end
      mstb_pkg::S_CLEAR: begin
        ctl.op  = mstb_pkg::CELL_CLEAR;
        state_d = mstb_pkg::S_IDLE;
      end
      default: state_d = mstb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mstb_pkg::S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      pick_q      <= '0;
      cfg_q       <= mstb_pkg::CFG_W'(16);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pick_q  <= pick_d;
      if (cfg_valid_i && cfg_ready_o) cfg_q <= cfg_data_i;
      if (state_q == mstb_pkg::S_EMIT && out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mstb_pkg::S_EMIT && out_load) begin
      out_par_q   <= reach ? par[idx_q] : '0;
      out_child_q <= idx_q;
      out_wt_q    <= reach ? pw[idx_q] : '0;
      out_reach_q <= reach;
      out_last_q  <= emit_last;
    end
  end

  assign tok_found[0] = 1'b0;
  assign tok_low[0]   = '0;
  assign tok_pick[0]  = '0;

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    mstb_cell #(
      .MAX_VERTICES(MAX_VERTICES),
      .WEIGHT_BITS (WEIGHT_BITS),
      .VW          (VW),
      .NW          (NW),
      .CELL_IDX    (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .n_i        (n_eff),
      .a_i        (from_vertex_i),
      .b_i        (to_vertex_i),
      .pick_i     (pick_d),
      .wt_i       (edge_weight_in_i),
      .tok_found_i(tok_found[k]),
      .tok_low_i  (tok_low[k]),
      .tok_pick_i (tok_pick[k]),
      .tok_found_o(tok_found[k+1]),
      .tok_low_o  (tok_low[k+1]),
      .tok_pick_o (tok_pick[k+1]),
      .key_valid_o(kv[k]),
      .in_tree_o  (it[k]),
      .parent_o   (par[k]),
      .parent_wt_o(pw[k])
    );
  end

  assign out_valid_o        = out_valid_q;
  assign parent_vertex_o    = out_par_q;
  assign child_vertex_o     = out_child_q;
  assign tree_edge_weight_o = out_wt_q;
  assign reachable_o        = out_reach_q;
  assign last_o             = out_last_q;

`ifndef SYNTHESIS
  a_child_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_child_q != '0)
    else $error("tree edge with child vertex zero");
  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_reach_q |-> out_wt_q == '0 && out_par_q == '0)
    else $error("unreachable vertex carries nonzero parent or weight");
  a_root_in_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mstb_pkg::S_EMIT |-> it[0])
    else $error("vertex zero missing from tree at emit");
  a_emit_to_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mstb_pkg::S_CLEAR |-> $past(state_q) == mstb_pkg::S_EMIT && out_valid_q &&
    out_last_q)
    else $error("clear without final tree edge");
`endif

endmodule

// ----- rtl/mstb_cell.sv -----
// One vertex cell: its adjacency row, Prim key state and one stage of the min-key token chain.
module mstb_cell #(
  parameter int MAX_VERTICES = mstb_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = mstb_pkg::WEIGHT_BITS_DEF,
  parameter int VW           = $clog2(MAX_VERTICES),
  parameter int NW           = $clog2(MAX_VERTICES + 1),
  parameter int CELL_IDX     = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mstb_pkg::cell_ctl_t           ctl_i,
  input  logic [NW-1:0]                 n_i,
  input  logic [VW-1:0]                 a_i,
  input  logic [VW-1:0]                 b_i,
  input  logic [VW-1:0]                 pick_i,
  input  logic signed [WEIGHT_BITS-1:0] wt_i,
  input  logic                          tok_found_i,
  input  logic signed [WEIGHT_BITS-1:0] tok_low_i,
  input  logic [VW-1:0]                 tok_pick_i,
  output logic                          tok_found_o,
  output logic signed [WEIGHT_BITS-1:0] tok_low_o,
  output logic [VW-1:0]                 tok_pick_o,
  output logic                          key_valid_o,
  output logic                          in_tree_o,
  output logic [VW-1:0]                 parent_o,
  output logic signed [WEIGHT_BITS-1:0] parent_wt_o
);

  localparam logic [VW-1:0] MY = VW'(CELL_IDX);

  logic signed [WEIGHT_BITS-1:0] w_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]       present_q, present_d;
  logic signed [WEIGHT_BITS-1:0] key_q;
  logic                          kv_q, kv_d;
  logic                          it_q, it_d;
  logic [VW-1:0]                 par_q;
  logic                          tok_found_q;
  logic signed [WEIGHT_BITS-1:0] tok_low_q;
  logic [VW-1:0]                 tok_pick_q;

  logic          active, ld_hit, ld_upd, rx_upd, cand;
  logic [VW-1:0] ld_col;

  assign active = NW'(CELL_IDX) < n_i;
  assign ld_hit = (a_i == MY) || (b_i == MY);
  assign ld_col = (a_i == MY) ? b_i : a_i;
  assign ld_upd = ld_hit && (!present_q[ld_col] || (wt_i < w_q[ld_col]));
  assign rx_upd = (pick_i != MY) && active && !it_q && present_q[pick_i] &&
                  (!kv_q || (w_q[pick_i] < key_q));
  assign cand   = active && !it_q && kv_q;

  always_comb begin
    present_d = present_q;
    kv_d      = kv_q;
    it_d      = it_q;
    case (ctl_i.op)
      mstb_pkg::CELL_LOAD: begin
        if (ld_upd) present_d[ld_col] = 1'b1;
      end
      mstb_pkg::CELL_INIT: begin
        kv_d = (CELL_IDX == 0);
        it_d = 1'b0;
      end
      mstb_pkg::CELL_RELAX: begin
        if (pick_i == MY) it_d = 1'b1;
        else if (rx_upd) kv_d = 1'b1;
      end
      mstb_pkg::CELL_CLEAR: begin
        present_d = '0;
        kv_d      = 1'b0;
        it_d      = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      kv_q        <= 1'b0;
      it_q        <= 1'b0;
      tok_found_q <= 1'b0;
    end else begin
      present_q   <= present_d;
      kv_q        <= kv_d;
      it_q        <= it_d;
      tok_found_q <= tok_found_i || cand;
    end
  end

  // Token keeps the earlier (lower index) vertex on equal keys.
  always_ff @(posedge clk_i) begin
    if (cand && (!tok_found_i || (key_q < tok_low_i))) begin
      tok_low_q  <= key_q;
      tok_pick_q <= MY;
    end else begin
      tok_low_q  <= tok_low_i;
      tok_pick_q <= tok_pick_i;
    end
    if (ctl_i.op == mstb_pkg::CELL_LOAD && ld_upd) w_q[ld_col] <= wt_i;
    if (ctl_i.op == mstb_pkg::CELL_INIT) begin
      key_q <= '0;
      par_q <= '0;
    end else if (ctl_i.op == mstb_pkg::CELL_RELAX && rx_upd) begin
      key_q <= w_q[pick_i];
      par_q <= pick_i;
    end
  end

  assign tok_found_o = tok_found_q;
  assign tok_low_o   = tok_low_q;
  assign tok_pick_o  = tok_pick_q;
  assign key_valid_o = kv_q;
  assign in_tree_o   = it_q;
  assign parent_o    = par_q;
  assign parent_wt_o = w_q[par_q];

endmodule
